/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the mover RTL, used by mtt_back.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every edge outside of reset.
`define MTT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define MTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MTT_ASSERT(lbl, clk, rstn, prop, msg)
`define MTT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/mtt_pkg.sv */
// ----------------------------------------------------------------------------
// mtt_pkg
// Types and constants for the constant-speed 3-D mover.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtt_pkg;

  localparam int CoordW   = 32;
  localparam int MagW     = 33;   // |target - pos|
  localparam int AccW     = 66;   // sum of three squares
  localparam int RootW    = 33;   // floor(sqrt(acc))
  localparam int StepW    = 28;   // elapsed * speed >> 12
  localparam int ArgW     = 24;
  localparam int ElapsedW = 16;
  localparam int ProdW    = MagW + StepW;
  localparam int CntW     = 6;
  localparam int RootIter = AccW / 2;
  localparam int DivIter  = MagW;
  localparam int QDepth   = 2;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef enum logic {
    K_TICK = 1'b0,
    K_MOVE = 1'b1
  } kind_t;

  // coordinates are the position on a tick, the goal on a move;
  // arg is elapsed (zero extended) on a tick, speed on a move
  typedef struct packed {
    kind_t                     kind;
    logic signed [CoordW-1:0]  cx;
    logic signed [CoordW-1:0]  cy;
    logic signed [CoordW-1:0]  cz;
    logic        [ArgW-1:0]    arg;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_STEP,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic signed [CoordW-1:0] sat34(input logic signed [CoordW+1:0] v);
    logic signed [CoordW+1:0] hi;
    logic signed [CoordW+1:0] lo;
    hi = (CoordW+2)'(34'sh0_7FFF_FFFF);
    lo = -(CoordW+2)'(34'sh0_8000_0000);
    if (v > hi)      sat34 = {1'b0, {(CoordW-1){1'b1}}};
    else if (v < lo) sat34 = {1'b1, {(CoordW-1){1'b0}}};
    else             sat34 = v[CoordW-1:0];
  endfunction

endpackage

/* design/mtt_front.sv */
// ----------------------------------------------------------------------------
// mtt_front
// Accepts items, sorts out the fields the item kind uses, and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtt_front import mtt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic signed [CoordW-1:0] in_pos_x,
  input  logic signed [CoordW-1:0] in_pos_y,
  input  logic signed [CoordW-1:0] in_pos_z,
  input  logic signed [CoordW-1:0] in_goal_x,
  input  logic signed [CoordW-1:0] in_goal_y,
  input  logic signed [CoordW-1:0] in_goal_z,
  input  logic [ElapsedW-1:0]      in_elapsed,
  input  logic [ArgW-1:0]          in_rate,
  output head_t                    head,
  input  logic                     pop
);

  item_t      q_r [QDepth];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  item_t      cls;
  logic       push;

  always_comb begin
    cls = '0;
    if (in_opcode == OP_MOVE) begin
      cls.kind = K_MOVE;
      cls.cx   = in_goal_x;
      cls.cy   = in_goal_y;
      cls.cz   = in_goal_z;
      cls.arg  = in_rate;
    end else begin
      cls.kind = K_TICK;
      cls.cx   = in_pos_x;
      cls.cy   = in_pos_y;
      cls.cz   = in_pos_z;
      cls.arg  = ArgW'(in_elapsed);
    end
  end

  assign in_stall   = (cnt_r == 2'(QDepth));
  assign push       = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

/* design/mtt_back.sv */
// ----------------------------------------------------------------------------
// mtt_back
// Executes queued items: target state, distance by shared digit-serial
// square root, step compare, per-axis restoring division, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtt_back import mtt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  head_t                    head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CoordW-1:0] out_new_x,
  output logic signed [CoordW-1:0] out_new_y,
  output logic signed [CoordW-1:0] out_new_z,
  output logic                     out_pos_written,
  output logic                     out_arrived,
  output logic                     out_still_moving
);

  state_t state_r, state_nxt;

  logic signed [CoordW-1:0] tgt_r [3];
  logic [ArgW-1:0]          speed_r;
  logic                     moving_r;

  logic signed [CoordW-1:0] pos_r [3];
  logic [MagW-1:0]          mag_r [3];
  logic                     neg_r [3];
  logic [StepW-1:0]         step_r;
  logic [AccW-1:0]          acc_r;
  logic [1:0]               axis_r;
  logic [CntW-1:0]          cnt_r;
  logic [RootW+2:0]         rem_r;
  logic [RootW-1:0]         root_r;
  logic [MagW-1:0]          drem_r [3];
  logic [MagW-1:0]          nlo_r [3];

  logic                     out_valid_r;
  logic signed [CoordW-1:0] out_c_r [3];
  logic                     out_pw_r, out_arr_r, out_mov_r;

  // control decode
  logic take, is_move, tick_idle, tick_run, arrive, last_sq, last_it, out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign take      = (state_r == ST_IDLE) && head.valid && !out_valid_r;
  assign is_move   = (head.item.kind == K_MOVE);
  assign tick_idle = take && !is_move && !moving_r;
  assign tick_run  = take && !is_move && moving_r;
  assign arrive    = ({{(RootW-StepW){1'b0}}, step_r} >= root_r);
  assign last_sq   = (axis_r == 2'd2);
  assign last_it   = (cnt_r == CntW'(RootIter - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (tick_run) state_nxt = ST_SQ;
      ST_SQ:   if (last_sq) state_nxt = ST_ROOT;
      ST_ROOT: if (last_it) state_nxt = ST_STEP;
      ST_STEP: state_nxt = arrive ? ST_DONE : ST_DIV;
      ST_DIV:  if (cnt_r == CntW'(DivIter - 1)) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop = take;
  end

  // datapath helpers
  logic signed [MagW-1:0]  dd [3];
  logic [AccW-1:0]         sq;
  logic [2*ArgW-9:0]       step_prod;
  logic [RootW+2:0]        r2, trial;
  logic [ProdW-1:0]        np [3];
  logic [MagW:0]           dr2 [3];
  logic                    dge [3];
  logic signed [CoordW+1:0] qs [3], sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i]  = {tgt_r[i][CoordW-1], tgt_r[i]} - MagW'(0);
      np[i]  = ProdW'(mag_r[i]) * ProdW'(step_r);
      dr2[i] = {drem_r[i], nlo_r[i][MagW-1]};
      dge[i] = (dr2[i] >= {1'b0, root_r});
      qs[i]  = neg_r[i] ? -$signed({1'b0, nlo_r[i]}) : $signed({1'b0, nlo_r[i]});
      sum[i] = $signed({{2{pos_r[i][CoordW-1]}}, pos_r[i]}) + qs[i];
    end
    dd[0] = {tgt_r[0][CoordW-1], tgt_r[0]} - {head.item.cx[CoordW-1], head.item.cx};
    dd[1] = {tgt_r[1][CoordW-1], tgt_r[1]} - {head.item.cy[CoordW-1], head.item.cy};
    dd[2] = {tgt_r[2][CoordW-1], tgt_r[2]} - {head.item.cz[CoordW-1], head.item.cz};
    sq        = AccW'(mag_r[axis_r]) * AccW'(mag_r[axis_r]);
    step_prod = (2*ArgW-8)'(head.item.arg[ElapsedW-1:0]) * (2*ArgW-8)'(speed_r);
    r2        = {rem_r[RootW:0], acc_r[AccW-1:AccW-2]};
    trial     = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      moving_r <= 1'b0;
      speed_r  <= '0;
      for (int i = 0; i < 3; i++) tgt_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_take) out_valid_r <= 1'b0;
      if (take && is_move) begin
        tgt_r[0] <= head.item.cx;
        tgt_r[1] <= head.item.cy;
        tgt_r[2] <= head.item.cz;
        speed_r  <= head.item.arg;
        moving_r <= 1'b1;
      end
      if (take && (is_move || tick_idle)) out_valid_r <= 1'b1;
      if (state_r == ST_DONE) out_valid_r <= 1'b1;
      if (state_r == ST_STEP && arrive) moving_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pw_r  <= 1'b0;
      out_arr_r <= 1'b0;
      out_mov_r <= is_move;
      for (int i = 0; i < 3; i++) out_c_r[i] <= '0;
    end
    if (tick_run) begin
      pos_r[0] <= head.item.cx;
      pos_r[1] <= head.item.cy;
      pos_r[2] <= head.item.cz;
      for (int i = 0; i < 3; i++) begin
        neg_r[i] <= dd[i][MagW-1];
        mag_r[i] <= dd[i][MagW-1] ? MagW'(-dd[i]) : MagW'(dd[i]);
      end
      step_r <= step_prod[2*ArgW-9:12];
      acc_r  <= '0;
      axis_r <= 2'd0;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end
    case (state_r)
      ST_SQ: begin
        acc_r  <= acc_r + sq;
        axis_r <= axis_r + 2'd1;
      end
      ST_ROOT: begin
        acc_r <= {acc_r[AccW-3:0], 2'b00};
        cnt_r <= cnt_r + CntW'(1);
        if (r2 >= trial) begin
          rem_r  <= r2 - trial;
          root_r <= {root_r[RootW-2:0], 1'b1};
        end else begin
          rem_r  <= r2;
          root_r <= {root_r[RootW-2:0], 1'b0};
        end
      end
      ST_STEP: begin
        cnt_r <= '0;
        for (int i = 0; i < 3; i++) begin
          drem_r[i] <= MagW'(np[i][ProdW-1:MagW]);
          nlo_r[i]  <= np[i][MagW-1:0];
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + CntW'(1);
        for (int i = 0; i < 3; i++) begin
          drem_r[i] <= dge[i] ? MagW'(dr2[i] - {1'b0, root_r}) : dr2[i][MagW-1:0];
          nlo_r[i]  <= {nlo_r[i][MagW-2:0], dge[i]};
        end
      end
      ST_DONE: begin
        out_pw_r  <= 1'b1;
        out_arr_r <= !moving_r;
        out_mov_r <= moving_r;
        for (int i = 0; i < 3; i++)
          out_c_r[i] <= moving_r ? sat34(sum[i]) : tgt_r[i];
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_new_x        = out_c_r[0];
  assign out_new_y        = out_c_r[1];
  assign out_new_z        = out_c_r[2];
  assign out_pos_written  = out_pw_r;
  assign out_arrived      = out_arr_r;
  assign out_still_moving = out_mov_r;

  `MTT_ASSERT(a_take_idle, clk, rst_n, pop |-> (state_r == ST_IDLE && !out_valid_r), "pop while busy")
  `MTT_ASSERT(a_arr_pw, clk, rst_n, (out_valid_r && out_arrived) |-> (out_pos_written && !out_still_moving), "arrived without position")
  `MTT_ASSERT(a_done_out, clk, rst_n, (state_r == ST_DONE) |=> (out_valid_r && out_pos_written), "done without result")
  `MTT_ASSERT(a_run_moving, clk, rst_n, (state_r == ST_SQ || state_r == ST_ROOT || state_r == ST_DIV) |-> moving_r, "work while stopped")

endmodule

/* design/move_toward_target_3d_top.sv */
// ----------------------------------------------------------------------------
// move_toward_target_3d_top
// Constant-speed mover toward a 3-D target point.
// ----------------------------------------------------------------------------
// Move items and ticks while stopped: queue head straight to the output
// register. Ticks while moving: queue handoff, 3 squares, 33 square-root
// digits, step compare, 33 divider steps in three parallel lanes, done, output
// register; a tick that reaches the target skips the divider. One item is
// worked on at a time; a 2-entry queue keeps accepting until full.
// Synchronous active-low reset clears target, speed and the moving flag.
`timescale 1ns / 1ps

module move_toward_target_3d_top import mtt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic signed [CoordW-1:0] in_pos_x,
  input  logic signed [CoordW-1:0] in_pos_y,
  input  logic signed [CoordW-1:0] in_pos_z,
  input  logic signed [CoordW-1:0] in_goal_x,
  input  logic signed [CoordW-1:0] in_goal_y,
  input  logic signed [CoordW-1:0] in_goal_z,
  input  logic [ElapsedW-1:0]      in_elapsed,
  input  logic [ArgW-1:0]          in_rate,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CoordW-1:0] out_new_x,
  output logic signed [CoordW-1:0] out_new_y,
  output logic signed [CoordW-1:0] out_new_z,
  output logic                     out_pos_written,
  output logic                     out_arrived,
  output logic                     out_still_moving
);

  head_t head;
  logic  pop;

  mtt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_pos_z  (in_pos_z),
    .in_goal_x (in_goal_x),
    .in_goal_y (in_goal_y),
    .in_goal_z (in_goal_z),
    .in_elapsed(in_elapsed),
    .in_rate   (in_rate),
    .head      (head),
    .pop       (pop)
  );

  mtt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_x       (out_new_x),
    .out_new_y       (out_new_y),
    .out_new_z       (out_new_z),
    .out_pos_written (out_pos_written),
    .out_arrived     (out_arrived),
    .out_still_moving(out_still_moving)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the constant-speed 3-D mover: a directed table of move and
// tick items followed by random move/tick sequences, with random idling on
// both channels, all checked against an in-bench position predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import mtt_pkg::*; ();

  typedef struct {
    logic        op;
    logic [31:0] px, py, pz, gx, gy, gz;
    logic [15:0] el;
    logic [23:0] rt;
  } mover_item_t;

  typedef struct packed {
    logic [31:0] nx, ny, nz;
    logic        wr, arr, mv;
  } mover_pos_t;

  typedef struct {
    mover_item_t it;
    logic        typed;  // expected result typed in the row
    mover_pos_t  res;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_opcode;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z, in_goal_x, in_goal_y, in_goal_z;
  logic [15:0] in_elapsed;
  logic [23:0] in_rate;
  logic out_valid, out_stall;
  logic signed [31:0] out_new_x, out_new_y, out_new_z;
  logic out_pos_written, out_arrived, out_still_moving;

  move_toward_target_3d_top DUT (.*);

  // predictor state
  logic [31:0] goal_x_q, goal_y_q, goal_z_q;
  logic [23:0] speed_q;
  logic        moving_q;

  mover_pos_t  expected_pos_q[$];
  int          errors;
  int          idle_cycles;
  bit          quiet;
  row_t        rows[$];

  function automatic logic [32:0] isqrt66(logic [65:0] s);
    logic [32:0] r;
    logic [32:0] c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      if ({33'd0, c} * {33'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] move_axis(logic [31:0] p, logic [31:0] t,
                                            logic [32:0] stp, logic [32:0] dlen);
    logic signed [33:0] d, sum;
    logic [32:0]        m;
    logic [65:0]        q;
    d = $signed({{2{t[31]}}, t}) - $signed({{2{p[31]}}, p});
    m = d[33] ? 33'(-d) : 33'(d);
    q = ({33'd0, m} * {33'd0, stp}) / {33'd0, dlen};
    sum = $signed({{2{p[31]}}, p}) + (d[33] ? -$signed(34'(q)) : $signed(34'(q)));
    if (sum > 34'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    if (sum < -34'sh0_8000_0000) return 32'h8000_0000;
    return sum[31:0];
  endfunction

  function automatic mover_pos_t predict_move(mover_item_t it);
    mover_pos_t r;
    logic signed [33:0] d;
    logic [32:0] m, dlen, stp;
    logic [65:0] acc;
    logic [39:0] prod;
    r = '{default: '0};
    if (it.op == OP_MOVE) begin
      goal_x_q = it.gx; goal_y_q = it.gy; goal_z_q = it.gz;
      speed_q = it.rt; moving_q = 1'b1; r.mv = 1'b1;
      return r;
    end
    if (!moving_q) return r;
    acc = '0;
    d = $signed({{2{goal_x_q[31]}}, goal_x_q}) - $signed({{2{it.px[31]}}, it.px});
    m = d[33] ? 33'(-d) : 33'(d); acc += {33'd0, m} * {33'd0, m};
    d = $signed({{2{goal_y_q[31]}}, goal_y_q}) - $signed({{2{it.py[31]}}, it.py});
    m = d[33] ? 33'(-d) : 33'(d); acc += {33'd0, m} * {33'd0, m};
    d = $signed({{2{goal_z_q[31]}}, goal_z_q}) - $signed({{2{it.pz[31]}}, it.pz});
    m = d[33] ? 33'(-d) : 33'(d); acc += {33'd0, m} * {33'd0, m};
    dlen = isqrt66(acc);
    prod = {24'd0, it.el} * {16'd0, speed_q};
    stp = 33'(prod >> 12);
    r.wr = 1'b1;
    if (stp >= dlen) begin
      moving_q = 1'b0;
      r.nx = goal_x_q; r.ny = goal_y_q; r.nz = goal_z_q; r.arr = 1'b1;
    end else begin
      r.nx = move_axis(it.px, goal_x_q, stp, dlen);
      r.ny = move_axis(it.py, goal_y_q, stp, dlen);
      r.nz = move_axis(it.pz, goal_z_q, stp, dlen);
      r.mv = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic mover_item_t rnd_item(logic op, logic [31:0] bx, by, bz);
    mover_item_t it;
    it.op = op;
    it.gx = rnd_coord(); it.gy = rnd_coord(); it.gz = rnd_coord();
    it.rt = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 4095) << 8);
    it.el = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
    if ($urandom_range(0, 1)) begin
      it.px = bx + ($urandom >> $urandom_range(1, 31));
      it.py = by - ($urandom >> $urandom_range(1, 31));
      it.pz = bz + ($urandom >> $urandom_range(1, 31));
    end else begin
      it.px = rnd_coord(); it.py = rnd_coord(); it.pz = rnd_coord();
    end
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(mover_item_t it, logic typed, mover_pos_t res);
    mover_pos_t e;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1; in_opcode <= it.op;
    in_pos_x <= it.px; in_pos_y <= it.py; in_pos_z <= it.pz;
    in_goal_x <= it.gx; in_goal_y <= it.gy; in_goal_z <= it.gz;
    in_elapsed <= it.el; in_rate <= it.rt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = predict_move(it);
    if (typed && e != res) begin
      $error("table row disagrees with predictor");
      errors++;
    end
    expected_pos_q.push_back(typed ? res : e);
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    mover_pos_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pos_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_pos_q.pop_front();
        if (out_new_x !== e.nx) begin $error("new_x exp %h got %h", e.nx, out_new_x); errors++; end
        if (out_new_y !== e.ny) begin $error("new_y exp %h got %h", e.ny, out_new_y); errors++; end
        if (out_new_z !== e.nz) begin $error("new_z exp %h got %h", e.nz, out_new_z); errors++; end
        if (out_pos_written !== e.wr) begin
          $error("pos_written exp %b got %b", e.wr, out_pos_written); errors++;
        end
        if (out_arrived !== e.arr) begin
          $error("arrived exp %b got %b", e.arr, out_arrived); errors++;
        end
        if (out_still_moving !== e.mv) begin
          $error("still_moving exp %b got %b", e.mv, out_still_moving); errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no accepted item on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    mover_item_t it;
    mover_pos_t  zero_res;
    row_t        rw;
    errors = 0; idle_cycles = 0; quiet = 1'b0;
    zero_res = '0;
    goal_x_q = '0; goal_y_q = '0; goal_z_q = '0; speed_q = '0; moving_q = 1'b0;
    rst_n = 1'b0; in_valid = 1'b0; in_opcode = OP_TICK;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_goal_x = '0; in_goal_y = '0; in_goal_z = '0; in_elapsed = '0; in_rate = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: op, pos, goal, elapsed, rate, typed, expected
    rows = '{
      '{'{OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0, 32'h0, 32'h0, 16'hFFFF, 24'h0},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0}},
      '{'{OP_MOVE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 24'h0},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
      '{'{OP_TICK, 32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1, 16'h0, 24'hFFFFFF},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0}},
      '{'{OP_MOVE, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          16'h0, 24'h0}, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
      '{'{OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
          16'hFFFF, 24'h0}, 1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          1'b1, 1'b0, 1'b1}},
      '{'{OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
          16'h1000, 24'h10_0000}, 1'b0, '{default: '0}},
      '{'{OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0,
          16'hFFFF, 24'hFFFFFF}, 1'b0, '{default: '0}},
      '{'{OP_MOVE, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h5000,
          16'h0, 24'h1000}, 1'b0, '{default: '0}},
      '{'{OP_TICK, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h1000, 24'h0},
        1'b0, '{default: '0}},
      '{'{OP_TICK, 32'h0001_0000, 32'hFFFF_0000, 32'h5000, 32'h0, 32'h0, 32'h0,
          16'h0, 24'h0}, 1'b0, '{default: '0}},
      '{'{OP_TICK, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          16'h1, 24'hFFFFFF}, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0}}
    };
    foreach (rows[i]) begin
      rw = rows[i];
      send_item(rw.it, rw.typed, rw.res);
    end

    // random: mostly a move, then ticks near the goal or anywhere
    for (int n = 0; n < 500; ) begin
      if (n > 420) quiet = 1'b1;
      it = rnd_item(OP_MOVE, 0, 0, 0);
      if ($urandom_range(0, 9) == 0) it.op = OP_TICK;
      send_item(it, 1'b0, zero_res); n++;
      repeat ($urandom_range(1, 8)) begin
        it = rnd_item(OP_TICK, goal_x_q, goal_y_q, goal_z_q);
        send_item(it, 1'b0, zero_res); n++;
      end
    end
    in_valid <= 1'b0;

    while (expected_pos_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

/* move_toward_target_3d_top.f */
+incdir+design
design/mtt_pkg.sv
design/mtt_front.sv
design/mtt_back.sv
design/move_toward_target_3d_top.sv
tb/tb.sv
